// ----- src/hines_pkg.sv -----
`timescale 1ns / 1ps

package hines_pkg;

    localparam int VW = 48;
    localparam int DIV_STEPS = 72;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    localparam logic [3:0] ACT_LD_DIAG = 4'd0;
    localparam logic [3:0] ACT_LD_OFF  = 4'd1;
    localparam logic [3:0] ACT_LD_RHS  = 4'd2;
    localparam logic [3:0] ACT_RD_RHS  = 4'd3;
    localparam logic [3:0] ACT_RD_DIAG = 4'd4;
    localparam logic [3:0] ACT_BEGIN   = 4'd5;
    localparam logic [3:0] ACT_FWD     = 4'd6;
    localparam logic [3:0] ACT_BWD     = 4'd7;
    localparam logic [3:0] ACT_SCALE   = 4'd8;
    localparam logic [3:0] ACT_CALC    = 4'd9;
    localparam logic [3:0] ACT_SETDIAG = 4'd10;
    localparam logic [3:0] ACT_FINISH  = 4'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FETCH,
        ST_DIV,
        ST_RDX,
        ST_RDY,
        ST_RDZ,
        ST_MUL,
        ST_WB,
        ST_OUT
    } state_t;

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
        mag = v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    // apply sign to a magnitude, saturate to 48 bits
    function automatic logic signed [VW-1:0] sat_mag(input logic [71:0] m, input logic neg);
        logic signed [VW-1:0] r;
        if (neg) begin
            if (m >= 72'(VMIN[VW-1:0])) begin
                r = VMIN;
            end else begin
                r = -$signed(m[VW-1:0]);
            end
        end else begin
            if (m > 72'(VMAX)) begin
                r = VMAX;
            end else begin
                r = $signed(m[VW-1:0]);
            end
        end
        sat_mag = r;
    endfunction

    function automatic logic signed [VW-1:0] qsub(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
        logic signed [VW:0] d;
        logic signed [VW-1:0] r;
        d = {a[VW-1], a} - {b[VW-1], b};
        if (d[VW] != d[VW-1]) begin
            r = d[VW] ? VMIN : VMAX;
        end else begin
            r = d[VW-1:0];
        end
        qsub = r;
    endfunction

endpackage

// ----- src/hines_elimination_op_engine.sv -----
`timescale 1ns / 1ps

// Hines elimination op engine. Each request on the s_ channel is one op of a
// precompiled elimination stream (action in s_tuser) and gives exactly one result on
// the m_ channel: the value in m_tdata, divide-by-zero in m_tuser, finish in m_tlast.
// One request is worked at a time; s_tready is high only between ops. fwd and bwd
// run one 24x24 multiplier over four partial products. scale and calc use a
// one-bit-per-cycle divider of 72 steps, and scale also multiplies; a zero divisor
// is resolved at once. A result held on m_ does not block the next request from
// being taken.
module hines_elimination_op_engine
    import hines_pkg::*;
#(
    parameter int NODES           = 256,
    parameter int OFFDIAG_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // node_index[7:0], target_index[15:8], load_value[63:16]
    input  logic [3:0]  s_tuser,   // action[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value[47:0]
    output logic        m_tuser,   // error[0]
    output logic        m_tlast
);

    localparam int NAW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int OAW = (OFFDIAG_ENTRIES > 1) ? $clog2(OFFDIAG_ENTRIES) : 1;

    state_t state_reg, state_next;

    logic [3:0]           act_reg, act_next;
    logic [7:0]           idx_reg, idx_next, tgt_reg, tgt_next;
    logic signed [VW-1:0] lv_reg, lv_next;
    logic signed [VW-1:0] opa_reg, opa_next, opb_reg, opb_next;
    logic signed [VW-1:0] res_reg, res_next;
    logic                 err_reg, err_next;
    logic signed [VW-1:0] pivot_reg, pivot_next, factor_reg, factor_next;
    logic [7:0]           rcur_reg, rcur_next, ocur_reg, ocur_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [47:0]          m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next, m_tlast_reg, m_tlast_next;

    logic signed [VW-1:0] d_mem [NODES];
    logic signed [VW-1:0] r_mem [NODES];
    logic signed [VW-1:0] o_mem [OFFDIAG_ENTRIES];
    logic signed [VW-1:0] d_q, r_q, o_q;
    logic [7:0]           r_sel;
    logic                 d_we, r_we, o_we;
    logic [7:0]           r_wsel;
    logic signed [VW-1:0] d_wd, r_wd, o_wd;

    logic idx_ok, tgt_ok, cur_ok, ocur_ok, idx_ook, r_ok, r_wok;
    logic signed [VW-1:0] val_d, val_r, val_o;

    logic                 mul_start, mul_done, div_start, div_done, div_err;
    logic signed [VW-1:0] mul_a, mul_p, div_a, div_b, div_q;

    always_comb begin
        idx_ok  = (32'(idx_reg) < NODES);
        tgt_ok  = (32'(tgt_reg) < NODES);
        cur_ok  = (32'(rcur_reg) < NODES);
        ocur_ok = (32'(ocur_reg) < OFFDIAG_ENTRIES);
        idx_ook = (32'(idx_reg) < OFFDIAG_ENTRIES);
        if (state_reg == ST_RDY) begin
            r_sel = tgt_reg;
            r_ok  = tgt_ok;
        end else if (act_reg == ACT_RD_RHS || act_reg == ACT_BWD) begin
            r_sel = idx_reg;
            r_ok  = idx_ok;
        end else begin
            r_sel = rcur_reg;
            r_ok  = cur_ok;
        end
        val_d = idx_ok ? d_q : '0;
        val_r = r_ok ? r_q : '0;
        val_o = ocur_ok ? o_q : '0;
    end

    always_ff @(posedge aclk) begin
        d_q <= d_mem[NAW'(idx_reg)];
        r_q <= r_mem[NAW'(r_sel)];
        o_q <= o_mem[OAW'(ocur_reg)];
    end

    always_ff @(posedge aclk) begin
        if (d_we) begin
            d_mem[NAW'(idx_reg)] <= d_wd;
        end
        if (r_we) begin
            r_mem[NAW'(r_wsel)] <= r_wd;
        end
        if (o_we) begin
            o_mem[OAW'(idx_reg)] <= o_wd;
        end
    end

    always_comb begin
        mul_a = (state_reg == ST_RDZ) ? opb_reg : val_o;
        div_a = (act_reg == ACT_SCALE) ? val_d : val_r;
        div_b = (act_reg == ACT_SCALE) ? pivot_reg : val_d;
    end

    hines_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (factor_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    hines_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (div_a),
        .b       (div_b),
        .done    (div_done),
        .q       (div_q),
        .err     (div_err)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                priority case (act_reg)
                    ACT_RD_RHS, ACT_RD_DIAG, ACT_BEGIN, ACT_SETDIAG,
                    ACT_FWD, ACT_BWD, ACT_SCALE, ACT_CALC: state_next = ST_FETCH;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_FETCH: begin
                priority case (act_reg)
                    ACT_FWD, ACT_BWD:    state_next = ST_MUL;
                    ACT_SCALE, ACT_CALC: state_next = ST_DIV;
                    default:             state_next = ST_OUT;
                endcase
            end
            ST_DIV: begin
                if (div_done) state_next = (act_reg == ACT_SCALE) ? ST_RDX : ST_WB;
            end
            ST_RDX: state_next = ST_RDY;
            ST_RDY: state_next = ST_RDZ;
            ST_RDZ: state_next = ST_MUL;
            ST_MUL: begin
                if (mul_done) state_next = ST_WB;
            end
            ST_WB:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        act_next      = act_reg;
        idx_next      = idx_reg;
        tgt_next      = tgt_reg;
        lv_next       = lv_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        res_next      = res_reg;
        err_next      = err_reg;
        pivot_next    = pivot_reg;
        factor_next   = factor_reg;
        rcur_next     = rcur_reg;
        ocur_next     = ocur_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        d_we          = 1'b0;
        r_we          = 1'b0;
        o_we          = 1'b0;
        d_wd          = lv_reg;
        r_wd          = lv_reg;
        o_wd          = lv_reg;
        r_wsel        = idx_reg;
        r_wok         = idx_ok;
        s_tready      = 1'b0;

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                act_next = s_tuser;
                idx_next = s_tdata[7:0];
                tgt_next = s_tdata[15:8];
                lv_next  = s_tdata[63:16];
            end
            ST_ISSUE: begin
                res_next = '0;
                err_next = 1'b0;
                d_we     = (act_reg == ACT_LD_DIAG) && idx_ok;
                r_we     = (act_reg == ACT_LD_RHS) && idx_ok;
                o_we     = (act_reg == ACT_LD_OFF) && idx_ook;
            end
            ST_FETCH: begin
                priority case (act_reg)
                    ACT_RD_RHS:  res_next = val_r;
                    ACT_RD_DIAG: res_next = val_d;
                    ACT_BEGIN: begin
                        pivot_next = val_d;
                        res_next   = val_d;
                        rcur_next  = '0;
                        ocur_next  = '0;
                    end
                    ACT_SETDIAG: begin
                        pivot_next = val_d;
                        res_next   = val_d;
                        rcur_next  = rcur_reg + 8'd1;
                    end
                    ACT_FWD: begin
                        opa_next  = val_d;
                        mul_start = 1'b1;
                    end
                    ACT_BWD: begin
                        opa_next  = val_r;
                        mul_start = 1'b1;
                    end
                    default: div_start = 1'b1;
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    factor_next = div_q;
                    err_next    = div_err;
                    res_next    = div_q;
                end
            end
            ST_RDX: begin
            end
            ST_RDY: opb_next = cur_ok ? r_q : '0;
            ST_RDZ: begin
                opa_next  = tgt_ok ? r_q : '0;
                mul_start = 1'b1;
            end
            ST_MUL: begin
                if (mul_done) res_next = qsub(opa_reg, mul_p);
            end
            ST_WB: begin
                d_wd = res_reg;
                r_wd = res_reg;
                priority case (act_reg)
                    ACT_FWD: begin
                        d_we      = idx_ok;
                        ocur_next = ocur_reg + 8'd1;
                    end
                    ACT_BWD: begin
                        r_we      = idx_ok;
                        ocur_next = ocur_reg + 8'd1;
                    end
                    ACT_SCALE: begin
                        r_wsel = tgt_reg;
                        r_wok  = tgt_ok;
                        r_we   = r_wok;
                    end
                    default: begin
                        r_wsel    = rcur_reg;
                        r_wok     = cur_ok;
                        r_we      = r_wok;
                        rcur_next = rcur_reg - 8'd1;
                    end
                endcase
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = err_reg;
                    m_tlast_next  = (act_reg == ACT_FINISH);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pivot_reg    <= '0;
            factor_reg   <= '0;
            rcur_reg     <= '0;
            ocur_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            err_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pivot_reg    <= pivot_next;
            factor_reg   <= factor_next;
            rcur_reg     <= rcur_next;
            ocur_reg     <= ocur_next;
            m_tvalid_reg <= m_tvalid_next;
            err_reg      <= err_next;
        end
        act_reg     <= act_next;
        idx_reg     <= idx_next;
        tgt_reg     <= tgt_next;
        lv_reg      <= lv_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- src/hines_mul.sv -----
`timescale 1ns / 1ps

module hines_mul
    import hines_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    output logic                 done,
    output logic signed [VW-1:0] p
);

    logic          busy_reg, busy_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [VW-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic          neg_reg, neg_next;
    logic [47:0]   pp_reg, pp_next;
    logic [1:0]    sh_reg, sh_next;
    logic [95:0]   acc_reg, acc_next;
    logic [23:0]   ha, hb;
    logic [95:0]   pp_sh;

    always_comb begin
        ha = cnt_reg[1] ? ma_reg[47:24] : ma_reg[23:0];
        hb = cnt_reg[0] ? mb_reg[47:24] : mb_reg[23:0];
        unique case (sh_reg)
            2'd0:    pp_sh = {48'b0, pp_reg};
            2'd1:    pp_sh = {24'b0, pp_reg, 24'b0};
            default: pp_sh = {pp_reg, 48'b0};
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            ma_next   = mag(a);
            mb_next   = mag(b);
            neg_next  = a[VW-1] ^ b[VW-1];
            acc_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_next = ha * hb;
                sh_next = {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0]};
            end
            if (cnt_reg != 3'd0) begin
                acc_next = acc_reg + pp_sh;
            end
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign p    = sat_mag(acc_reg[95:24], neg_reg);

endmodule

// ----- src/hines_div.sv -----
`timescale 1ns / 1ps

module hines_div
    import hines_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    output logic                 done,
    output logic signed [VW-1:0] q,
    output logic                 err
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic [VW-1:0]        rem_reg, rem_next;
    logic [VW-1:0]        mb_reg, mb_next;
    logic [71:0]          sh_reg, sh_next;
    logic                 neg_reg, neg_next;
    logic signed [VW-1:0] q_reg, q_next;
    logic                 err_reg, err_next;
    logic [VW:0]          rem2, diff;
    logic                 ge;

    always_comb begin
        rem2 = {rem_reg, sh_reg[71]};
        diff = rem2 - {1'b0, mb_reg};
        ge   = (rem2 >= {1'b0, mb_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        mb_next   = mb_reg;
        sh_next   = sh_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        err_next  = err_reg;
        if (start) begin
            if (b == '0) begin
                done_next = 1'b1;
                err_next  = 1'b1;
                q_next    = a[VW-1] ? VMIN : VMAX;
            end else begin
                busy_next = 1'b1;
                err_next  = 1'b0;
                cnt_next  = '0;
                rem_next  = '0;
                mb_next   = mag(b);
                sh_next   = {mag(a), 24'b0};
                neg_next  = a[VW-1] ^ b[VW-1];
            end
        end else if (busy_reg) begin
            if (cnt_reg == 7'(DIV_STEPS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = sat_mag(sh_reg, neg_reg);
            end else begin
                rem_next = ge ? diff[VW-1:0] : rem2[VW-1:0];
                sh_next  = {sh_reg[70:0], ge};
                cnt_next = cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            err_reg  <= err_next;
        end
        rem_reg <= rem_next;
        mb_reg  <= mb_next;
        sh_reg  <= sh_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign err  = err_reg;

endmodule

// ----- src/hines_checker.sv -----
`timescale 1ns / 1ps

module hines_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while an op is in flight");

    a_finish_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 48'h0)
        else $error("finish result carries a value");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present right after reset");

    a_finish_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser))
        else $error("finish marked with divide error");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind hines_elimination_op_engine hines_checker u_hines_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_hines_elimination_op_engine.sv -----
`timescale 1ns / 1ps

module tb_hines_elimination_op_engine;
    import hines_pkg::*;

    typedef struct packed {
        logic [3:0]  act;
        logic [47:0] lval;
        logic [7:0]  tgt;
        logic [7:0]  node;
    } op_req_t;

    typedef struct packed {
        logic [47:0] value;
        logic        done;
        logic        err;
    } op_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    hines_elimination_op_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [47:0] diag_mem [256];
    logic signed [47:0] off_mem [256];
    logic signed [47:0] rhs_mem [256];
    logic signed [47:0] pivot, factor;
    logic [7:0]         rcur, ocur;

    op_req_t pending_ops[$];
    op_res_t expected_results[$];
    int      errors = 0;
    int      send_idle = 0, recv_stall = 0;
    longint  cycles = 0;

    function automatic logic signed [47:0] sat_apply(logic [71:0] m, bit neg);
        if (neg) return (m >= 72'h800000000000) ? VMIN : -$signed(m[47:0]);
        return (m > 72'h7FFFFFFFFFFF) ? VMAX : $signed(m[47:0]);
    endfunction

    function automatic logic signed [47:0] fx_sub(logic signed [47:0] a, logic signed [47:0] b);
        logic signed [48:0] d;
        d = 49'(a) - 49'(b);
        if (d > 49'sh7FFFFFFFFFFF) return VMAX;
        if (d < -49'sh800000000000) return VMIN;
        return d[47:0];
    endfunction

    function automatic logic [47:0] magnitude(logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic logic signed [47:0] fx_mul(logic signed [47:0] a, logic signed [47:0] b);
        logic [95:0] p;
        p = 96'(magnitude(a)) * 96'(magnitude(b));
        return sat_apply((p >> 24) > 96'hFFFFFFFFFFFFFFFFFF ? '1 : 72'(p >> 24),
                         a[47] != b[47]);
    endfunction

    function automatic logic signed [47:0] fx_div(logic signed [47:0] a, logic signed [47:0] b,
                                                   output bit dz);
        logic [95:0] q;
        dz = 0;
        if (b == 0) begin
            dz = 1;
            return a[47] ? VMIN : VMAX;
        end
        q = (96'(magnitude(a)) << 24) / 96'(magnitude(b));
        return sat_apply(q > 96'hFFFFFFFFFFFFFFFFFF ? '1 : 72'(q), a[47] != b[47]);
    endfunction

    function automatic op_res_t predict_op(op_req_t r);
        op_res_t res;
        logic signed [47:0] v;
        bit dz;
        res = '0;
        dz = 0;
        case (r.act)
            ACT_LD_DIAG: diag_mem[r.node] = r.lval;
            ACT_LD_OFF:  off_mem[r.node] = r.lval;
            ACT_LD_RHS:  rhs_mem[r.node] = r.lval;
            ACT_RD_RHS:  res.value = rhs_mem[r.node];
            ACT_RD_DIAG: res.value = diag_mem[r.node];
            ACT_BEGIN: begin
                pivot = diag_mem[r.node]; rcur = 0; ocur = 0; res.value = pivot;
            end
            ACT_FWD: begin
                v = fx_sub(diag_mem[r.node], fx_mul(off_mem[ocur], factor));
                diag_mem[r.node] = v; ocur++; res.value = v;
            end
            ACT_BWD: begin
                v = fx_sub(rhs_mem[r.node], fx_mul(off_mem[ocur], factor));
                rhs_mem[r.node] = v; ocur++; res.value = v;
            end
            ACT_SCALE: begin
                factor = fx_div(diag_mem[r.node], pivot, dz);
                v = fx_sub(rhs_mem[r.tgt], fx_mul(rhs_mem[rcur], factor));
                rhs_mem[r.tgt] = v; res.value = v;
            end
            ACT_CALC: begin
                factor = fx_div(rhs_mem[rcur], diag_mem[r.node], dz);
                rhs_mem[rcur] = factor; rcur--; res.value = factor;
            end
            ACT_SETDIAG: begin
                rcur++; pivot = diag_mem[r.node]; res.value = pivot;
            end
            ACT_FINISH: res.done = 1;
            default: ;
        endcase
        res.err = dz;
        return res;
    endfunction

    function automatic logic [47:0] rand_value();
        case ($urandom_range(0, 5))
            0: return VMAX;
            1: return VMIN;
            2: return 48'($signed($urandom_range(0, 8)) - 4) << 24;
            3: return 48'($signed(32'($urandom)) >>> $urandom_range(0, 16));
            4: return 48'h0;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic void push_op(logic [3:0] a, logic [7:0] n, logic [7:0] t,
                                    logic [47:0] v);
        op_req_t r;
        r.act = a; r.node = n; r.tgt = t; r.lval = v;
        pending_ops.push_back(r);
    endfunction

    // all entries written at start so no op reads an unwritten store entry
    task automatic fill_stores();
        for (int i = 0; i < 256; i++) begin
            push_op(ACT_LD_DIAG, 8'(i), 8'($urandom), rand_value());
            push_op(ACT_LD_OFF, 8'(i), 8'($urandom), rand_value());
            push_op(ACT_LD_RHS, 8'(i), 8'($urandom), rand_value());
        end
    endtask

    function automatic logic [3:0] rand_elim_act();
        case ($urandom_range(0, 9))
            0: return ACT_BEGIN;
            1, 2: return ACT_FWD;
            3, 4: return ACT_BWD;
            5: return ACT_SCALE;
            6: return ACT_CALC;
            7: return ACT_SETDIAG;
            8: return 4'($urandom_range(0, 4));
            default: return 4'($urandom_range(11, 15));
        endcase
    endfunction

    task automatic run_phase(int count, int s_pct, int r_pct);
        for (int i = 0; i < count; i++)
            push_op(rand_elim_act(), 8'($urandom), 8'($urandom), rand_value());
        send_idle = s_pct;
        recv_stall = r_pct;
        while (pending_ops.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_op(op_req_t'({s_tuser, s_tdata})));
            if (!(s_tvalid && !s_tready)) begin
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    op_req_t r;
                    r = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= r.act;
                    s_tdata <= {r.lval, r.tgt, r.node};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h/%b/%b", $time, m_tdata, m_tlast, m_tuser);
                    errors++;
                end else begin
                    op_res_t e;
                    e = expected_results.pop_front();
                    if (e.value !== m_tdata || e.done !== m_tlast || e.err !== m_tuser) begin
                        $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                                 e.value, e.done, e.err, m_tdata, m_tlast, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
        if (cycles > 2000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 256; i++) begin
            diag_mem[i] = 0; off_mem[i] = 0; rhs_mem[i] = 0;
        end
        pivot = 0; factor = 0; rcur = 0; ocur = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        fill_stores();
        // directed: zero divisors, extremes, every action but the offdiag load
        push_op(ACT_LD_DIAG, 8'd0, 8'd0, 48'h0);
        push_op(ACT_LD_DIAG, 8'd255, 8'd0, VMAX);
        push_op(ACT_LD_RHS, 8'd0, 8'd0, VMIN);
        push_op(ACT_BEGIN, 8'd0, 8'd0, 48'h0);
        push_op(ACT_SCALE, 8'd255, 8'd1, 48'h0);
        push_op(ACT_CALC, 8'd0, 8'd0, 48'h0);
        push_op(ACT_LD_RHS, 8'd1, 8'd0, 48'h1000000);
        push_op(ACT_SETDIAG, 8'd255, 8'd0, 48'h0);
        push_op(ACT_CALC, 8'd0, 8'd0, 48'h0);
        push_op(ACT_BEGIN, 8'd255, 8'd0, 48'h0);
        push_op(ACT_FWD, 8'd255, 8'd0, 48'h0);
        push_op(ACT_BWD, 8'd0, 8'd0, 48'h0);
        push_op(ACT_SCALE, 8'd255, 8'd255, 48'h0);
        push_op(ACT_CALC, 8'd255, 8'd0, 48'h0);
        push_op(ACT_RD_RHS, 8'd255, 8'd0, 48'h0);
        push_op(ACT_RD_DIAG, 8'd255, 8'd0, 48'h0);
        push_op(ACT_FINISH, 8'd0, 8'd0, 48'h0);
        push_op(4'd12, 8'hFF, 8'hFF, '1);
        push_op(4'd15, 8'h00, 8'h00, 48'h0);
        run_phase(165, 0, 0);
        run_phase(165, 50, 0);
        run_phase(165, 0, 50);
        run_phase(165, 18, 18);
        run_phase(165, 0, 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
